[hdl/kss_pkg.sv]
// kss_pkg: shared constants and types for the k-th smallest selector
// used by kss_store, kss_seq and kth_smallest_selector_unit; no dependencies
`timescale 1ns / 1ps

package kss_pkg;

    localparam int DATA_W    = 32;
    localparam int K_CFG_W   = 4;
    localparam int MAX_K_DEF = 8;
    localparam logic [K_CFG_W-1:0] K_RESET = K_CFG_W'(5);

    // result of one finished set
    typedef struct packed {
        logic [DATA_W-1:0] kth_value;
        logic              valid_res;
    } t_kss_res;

endpackage

[hdl/kss_store.sv]
// kss_store: store of kept values, one write port and one registered read port
// depends on kss_pkg for the data width
`timescale 1ns / 1ps

module kss_store #(
    parameter int MAX_K = kss_pkg::MAX_K_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0]   i_waddr,
    input  logic [kss_pkg::DATA_W-1:0]                     i_wdata,
    input  logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0]   i_raddr,
    output logic [kss_pkg::DATA_W-1:0]                     o_rdata
);
    import kss_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_K];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/kss_seq.sv]
// kss_seq: sequencer that inserts each value into the sorted store
// depends on kss_pkg; drives the ports of kss_store
`timescale 1ns / 1ps

module kss_seq #(
    parameter int MAX_K = kss_pkg::MAX_K_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic [kss_pkg::K_CFG_W-1:0]                    i_k_cfg,
    input  logic                                           i_in_valid,
    output logic                                           o_in_ready,
    input  logic [kss_pkg::DATA_W-1:0]                     i_value,
    input  logic                                           i_last,
    input  logic                                           i_out_free,
    output logic                                           o_done,
    output kss_pkg::t_kss_res                              o_res,
    output logic                                           o_we,
    output logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0]   o_waddr,
    output logic [kss_pkg::DATA_W-1:0]                     o_wdata,
    output logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0]   o_raddr,
    input  logic [kss_pkg::DATA_W-1:0]                     i_rdata
);
    import kss_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);
    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_fill_new, n_fill_new;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_i, n_i;
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_top, n_top;
    logic              r_last, n_last;
    logic              r_first, n_first;

    logic [CW-1:0]     k_eff;
    logic [CW-1:0]     n_start;
    logic [CW-1:0]     rd_idx;
    logic              rd_gt_v;

    // clamp the configured rank into 1 .. MAX_K
    always_comb begin
        if (i_k_cfg == '0) begin
            k_eff = CW'(1);
        end else if (32'(i_k_cfg) > 32'(MAX_K)) begin
            k_eff = CW'(MAX_K);
        end else begin
            k_eff = CW'(i_k_cfg);
        end
    end

    assign n_start = (r_fill > k_eff) ? k_eff : r_fill;
    assign rd_gt_v = $signed(i_rdata) > $signed(r_v);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_fill_new = r_fill_new;
        n_k        = r_k;
        n_i        = r_i;
        n_v        = r_v;
        n_top      = r_top;
        n_last     = r_last;
        n_first    = r_first;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_we       = 1'b0;
        o_waddr    = AW'(r_i);
        o_wdata    = r_v;
        rd_idx     = '0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_idx     = n_start - CW'(1);
                if (i_in_valid) begin
                    n_v     = i_value;
                    n_last  = i_last;
                    n_k     = k_eff;
                    n_first = 1'b1;
                    n_fill  = n_start;
                    if (n_start == k_eff) begin
                        // full: look at the largest kept value first
                        n_state = ST_CHECK;
                    end else begin
                        n_i        = n_start;
                        n_fill_new = n_start + CW'(1);
                        n_state    = ST_SHIFT;
                    end
                end
            end
            ST_CHECK: begin
                rd_idx = r_k - CW'(2);
                if (rd_gt_v) begin
                    // drop the largest, insert among the k-1 below it
                    n_i        = r_k - CW'(1);
                    n_fill_new = r_k;
                    n_state    = ST_SHIFT;
                end else begin
                    n_top   = i_rdata;
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                o_we   = 1'b1;
                rd_idx = r_i - CW'(2);
                if ((r_i != '0) && rd_gt_v) begin
                    // move entry i-1 up one place
                    o_wdata = i_rdata;
                    if (r_first) begin
                        n_top = i_rdata;
                    end
                    n_first = 1'b0;
                    n_i     = r_i - CW'(1);
                end else begin
                    o_wdata = r_v;
                    if (r_first) begin
                        n_top = r_v;
                    end
                    n_first = 1'b0;
                    n_fill  = r_fill_new;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (i_out_free) begin
                    o_done  = 1'b1;
                    n_fill  = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_raddr         = AW'(rd_idx);
    assign o_res.valid_res = (r_fill == r_k);
    assign o_res.kth_value = (r_fill == r_k) ? r_top : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_new <= n_fill_new;
        r_k        <= n_k;
        r_i        <= n_i;
        r_v        <= n_v;
        r_top      <= n_top;
        r_last     <= n_last;
        r_first    <= n_first;
    end

endmodule

[hdl/kth_smallest_selector_unit.sv]
// kth_smallest_selector_unit: top level of the k-th smallest selector
// depends on kss_pkg, kss_store and kss_seq
`timescale 1ns / 1ps

// Takes a stream of signed 32-bit values; tlast marks the final value of a set.
// The block keeps the k smallest values of the set in ascending order in a
// small synchronous memory and, after the last value, sends one item holding
// the k-th smallest value (tdata) and a flag (tuser) that is 1 when at least
// k values arrived; with fewer values tdata is 0 and the flag 0. k comes from
// a 4-bit register (reset 5), read at each input item; 0 counts as 1 and
// values above MAX_K count as MAX_K. The sorted insertion of an input item
// moves one kept entry up per cycle through the memory's single read and
// write ports, so a value that lands low in the list costs more. A finished
// result waits in an output register, and the next input item is taken while
// it waits; a further last item whose result finds that register still full
// holds the input until it drains.
module kth_smallest_selector_unit #(
    parameter int MAX_K = kss_pkg::MAX_K_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: rank k
    input  logic                            i_cfg_we,
    input  logic [kss_pkg::K_CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // [31:0] value
    input  logic                            s_axis_tlast,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [31:0] kth_value
    output logic                            m_axis_tuser    // [0] valid_res
);
    import kss_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    // rank register
    logic [K_CFG_W-1:0] r_k_cfg;

    // output register
    logic     r_out_valid;
    t_kss_res r_out;

    // sequencer to store
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // sequencer result
    logic     seq_done;
    t_kss_res seq_res;
    logic     out_free;

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_cfg <= K_RESET;
        end else if (i_cfg_we) begin
            r_k_cfg <= i_cfg_wdata;
        end
    end

    kss_seq #(
        .MAX_K (MAX_K)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_k_cfg    (r_k_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_value    (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_out_free (out_free),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    // kept values, ascending from address 0
    kss_store #(
        .MAX_K (MAX_K)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result holding stage; loaded only when free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out <= seq_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.kth_value;
    assign m_axis_tuser  = r_out.valid_res;

endmodule
